>>> design/amep_pkg.sv
`default_nettype none

package amep_pkg;

    // Default limit on recorded processors.
    localparam int MAX_CPUS_DEFAULT = 16;

    // Depth of the queue between the byte parser and the result sequencer.
    localparam int QUEUE_DEPTH = 4;

    // Table layout.
    localparam logic [31:0] HDR_BYTES     = 32'd44;
    localparam logic [7:0]  MIN_ENTRY_LEN = 8'd2;
    localparam logic [7:0]  MIN_FIELD_LEN = 8'd8;

    // Entry type codes.
    localparam logic [7:0] TYPE_LOCAL_APIC = 8'd0;
    localparam logic [7:0] TYPE_IO_APIC    = 8'd1;

    // Result kind codes.
    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One parsed byte's outcome: a processor record, a summary, or both.
    typedef struct packed {
        logic        has_rec;
        logic        has_sum;
        logic [3:0]  slot;
        logic [7:0]  apic_id;
        logic [7:0]  acpi_id;
        logic [4:0]  cpu_count;
        logic [31:0] io_base;
        logic        halted;
    } parse_evt_t;

endpackage

`default_nettype wire

>>> design/amep_front.sv
`default_nettype none

module amep_front #(
    parameter int MAX_CPUS = amep_pkg::MAX_CPUS_DEFAULT
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [7:0]          s_data,
    input  wire                 s_start_req,
    input  wire                 q_full,
    output logic                q_push,
    output amep_pkg::parse_evt_t q_evt
);

    localparam int CNT_W = $clog2(MAX_CPUS + 1);

    logic [31:0]      off_reg, off_next, eff_off;
    logic [31:0]      len_reg, len_next, eff_len;
    logic [7:0]       eoff_reg, eoff_next, eff_eoff;
    logic [7:0]       etype_reg, etype_next, eff_etype;
    logic [7:0]       elen_reg, elen_next, eff_elen;
    logic [31:0]      ebytes_reg, ebytes_next, eff_ebytes;
    logic [7:0]       acpi_reg, acpi_next, eff_acpi;
    logic [7:0]       apic_reg, apic_next, eff_apic;
    logic [CNT_W-1:0] cnt_reg, cnt_next, eff_cnt;
    logic [31:0]      io_reg, io_next, eff_io;
    logic             halt_reg, halt_next, eff_halt;
    logic             fin_reg, fin_next, eff_fin;

    logic             accept;
    logic             rec;
    logic             sum;
    logic             bad;
    logic [CNT_W+4:0] cnt_ext;
    logic [CNT_W+3:0] slot_ext;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Parse one byte: a start request discards all progress first.
    always_comb begin
        eff_off    = s_start_req ? '0 : off_reg;
        eff_len    = s_start_req ? '0 : len_reg;
        eff_eoff   = s_start_req ? '0 : eoff_reg;
        eff_etype  = s_start_req ? '0 : etype_reg;
        eff_elen   = s_start_req ? '0 : elen_reg;
        eff_ebytes = s_start_req ? '0 : ebytes_reg;
        eff_acpi   = s_start_req ? '0 : acpi_reg;
        eff_apic   = s_start_req ? '0 : apic_reg;
        eff_cnt    = s_start_req ? '0 : cnt_reg;
        eff_io     = s_start_req ? '0 : io_reg;
        eff_halt   = s_start_req ? 1'b0 : halt_reg;
        eff_fin    = s_start_req ? 1'b0 : fin_reg;

        off_next    = eff_off;
        len_next    = eff_len;
        eoff_next   = eff_eoff;
        etype_next  = eff_etype;
        elen_next   = eff_elen;
        ebytes_next = eff_ebytes;
        acpi_next   = eff_acpi;
        apic_next   = eff_apic;
        cnt_next    = eff_cnt;
        io_next     = eff_io;
        halt_next   = eff_halt;
        fin_next    = eff_fin;
        rec         = 1'b0;
        sum         = 1'b0;
        bad         = 1'b0;

        if (!eff_fin) begin
            // Header bytes 4 to 7 carry the little-endian table length.
            if (eff_off[31:2] == 30'd1) begin
                len_next[{eff_off[1:0], 3'b000} +: 8] = s_data;
            end

            // Entry walk after the header.
            if (eff_off >= amep_pkg::HDR_BYTES && !eff_halt) begin
                priority if (eff_eoff == 8'd0) begin
                    etype_next  = s_data;
                    ebytes_next = '0;
                end else if (eff_eoff == 8'd1) begin
                    elen_next = s_data;
                    if (s_data < amep_pkg::MIN_ENTRY_LEN) begin
                        halt_next = 1'b1;
                        bad       = 1'b1;
                    end
                end else if (eff_eoff == 8'd2) begin
                    acpi_next = s_data;
                end else if (eff_eoff == 8'd3) begin
                    apic_next = s_data;
                end else if (eff_eoff <= 8'd7) begin
                    ebytes_next[{eff_eoff[1:0], 3'b000} +: 8] = s_data;
                end

                if (!bad) begin
                    if (eff_eoff != 8'd0 &&
                        ({1'b0, eff_eoff} + 9'd1) == {1'b0, elen_next}) begin
                        // Last byte of the entry: act on its fields.
                        if (elen_next >= amep_pkg::MIN_FIELD_LEN) begin
                            if (etype_next == amep_pkg::TYPE_LOCAL_APIC && ebytes_next[0] &&
                                eff_cnt < CNT_W'(MAX_CPUS)) begin
                                rec      = 1'b1;
                                cnt_next = eff_cnt + 1'b1;
                            end else if (etype_next == amep_pkg::TYPE_IO_APIC &&
                                         eff_io == 32'd0) begin
                                io_next = ebytes_next;
                            end
                        end
                        eoff_next = 8'd0;
                    end else begin
                        eoff_next = eff_eoff + 8'd1;
                    end
                end
            end

            // The summary comes at the table end, never before the last header byte.
            if (eff_off >= (amep_pkg::HDR_BYTES - 32'd1) && (eff_off + 32'd1) >= len_next) begin
                sum      = 1'b1;
                fin_next = 1'b1;
            end else begin
                off_next = eff_off + 32'd1;
            end
        end
    end

    // Pack the outcome for the result sequencer.
    assign cnt_ext  = {{5{1'b0}}, cnt_next};
    assign slot_ext = {{4{1'b0}}, eff_cnt};

    always_comb begin
        q_push          = accept && (rec || sum);
        q_evt.has_rec   = rec;
        q_evt.has_sum   = sum;
        q_evt.slot      = slot_ext[3:0];
        q_evt.apic_id   = apic_next;
        q_evt.acpi_id   = acpi_next;
        q_evt.cpu_count = cnt_ext[4:0];
        q_evt.io_base   = io_next;
        q_evt.halted    = halt_next;
    end

    // Parser state advances on every accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg    <= '0;
            len_reg    <= '0;
            eoff_reg   <= '0;
            etype_reg  <= '0;
            elen_reg   <= '0;
            ebytes_reg <= '0;
            acpi_reg   <= '0;
            apic_reg   <= '0;
            cnt_reg    <= '0;
            io_reg     <= '0;
            halt_reg   <= 1'b0;
            fin_reg    <= 1'b0;
        end else if (accept) begin
            off_reg    <= off_next;
            len_reg    <= len_next;
            eoff_reg   <= eoff_next;
            etype_reg  <= etype_next;
            elen_reg   <= elen_next;
            ebytes_reg <= ebytes_next;
            acpi_reg   <= acpi_next;
            apic_reg   <= apic_next;
            cnt_reg    <= cnt_next;
            io_reg     <= io_next;
            halt_reg   <= halt_next;
            fin_reg    <= fin_next;
        end
    end

endmodule

`default_nettype wire

>>> design/amep_queue.sv
`default_nettype none

module amep_queue (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  amep_pkg::parse_evt_t push_evt,
    input  wire                  pop,
    output logic                 full,
    output logic                 head_valid,
    output amep_pkg::parse_evt_t head_evt
);

    localparam int DEPTH = amep_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    amep_pkg::parse_evt_t mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_evt   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Storage is written at the tail.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_evt;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // The parser must never offer a request when the queue is full.
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("request pushed into a full queue");

    // The fill count never exceeds the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");
`endif

endmodule

`default_nettype wire

>>> design/amep_back.sv
`default_nettype none

module amep_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  q_valid,
    input  amep_pkg::parse_evt_t q_evt,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic                 m_kind,
    output logic [3:0]           m_cpu_index,
    output logic [7:0]           m_apic_id,
    output logic [7:0]           m_acpi_id,
    output logic [4:0]           m_cpu_count,
    output logic [31:0]          m_ioapic_base,
    output logic                 m_stopped_early,
    output logic                 m_last
);

    logic        valid_reg;
    logic        phase_reg, phase_next;
    logic        kind_reg;
    logic [3:0]  idx_reg;
    logic [7:0]  apic_reg;
    logic [7:0]  acpi_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] io_reg;
    logic        halt_reg;
    logic        last_reg;
    logic        load;
    logic        emit_rec;

    // The output register takes a new result whenever it is empty or being drained.
    assign load     = q_valid && (!valid_reg || m_ready);
    assign emit_rec = q_evt.has_rec && !phase_reg;

    always_comb begin
        q_pop      = 1'b0;
        phase_next = phase_reg;
        if (load) begin
            if (emit_rec && q_evt.has_sum) begin
                phase_next = 1'b1;
            end else begin
                q_pop      = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: a processor record first, then the summary.
    always_ff @(posedge aclk) begin
        if (load) begin
            cnt_reg  <= q_evt.cpu_count;
            io_reg   <= q_evt.io_base;
            halt_reg <= q_evt.halted;
            if (emit_rec) begin
                kind_reg <= amep_pkg::KIND_RECORD;
                idx_reg  <= q_evt.slot;
                apic_reg <= q_evt.apic_id;
                acpi_reg <= q_evt.acpi_id;
                last_reg <= !q_evt.has_sum;
            end else begin
                kind_reg <= amep_pkg::KIND_SUMMARY;
                idx_reg  <= '0;
                apic_reg <= '0;
                acpi_reg <= '0;
                last_reg <= 1'b1;
            end
        end
    end

    assign m_valid         = valid_reg;
    assign m_kind          = kind_reg;
    assign m_cpu_index     = idx_reg;
    assign m_apic_id       = apic_reg;
    assign m_acpi_id       = acpi_reg;
    assign m_cpu_count     = cnt_reg;
    assign m_ioapic_base   = io_reg;
    assign m_stopped_early = halt_reg;
    assign m_last          = last_reg;

`ifndef NO_ASSERTIONS
    // Half-way through a two-result request, that request is still at the head.
    a_phase_holds_head: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (q_valid && q_evt.has_rec && q_evt.has_sum))
        else $error("second result pending without its request");

    // A record that is not last is always followed by its summary.
    a_record_then_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && emit_rec && q_evt.has_sum) |=> phase_reg)
        else $error("summary lost after a record");
`endif

endmodule

`default_nettype wire

>>> design/acpi_madt_entry_parser.sv
// Streaming parser for an ACPI interrupt-controller table.
// Input channel (s_valid/s_ready): one table byte per request in memory order,
// with s_start_req set on header byte 0 of a new table; a start request clears
// all counts and drops any table in progress without a summary. After reset the
// first byte is taken as header byte 0 even without s_start_req.
// Output channel (m_valid/m_ready): processor records (m_kind = 0) for each
// enabled local controller entry up to MAX_CPUS, and one summary (m_kind = 1)
// at the table end; m_last marks the final result caused by a byte.
// Throughput: one byte per cycle while the request queue is not full; the byte
// parser updates its registered state on each accepted byte. A byte that yields
// a record and a summary holds the result sequencer while it emits both results,
// absorbed by the four-entry request queue between them. With the queue empty,
// the request enters the queue when its byte is accepted, and the result
// sequencer then loads it into the output register, which raises m_valid.
// When the receiver stalls, results wait in the output register and the queue;
// s_ready falls only once the queue is full. Reset (aresetn low, synchronous)
// empties the queue and output register and clears all parser state.
`default_nettype none

module acpi_madt_entry_parser #(
    parameter int MAX_CPUS = amep_pkg::MAX_CPUS_DEFAULT
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_data,
    input  wire         s_start_req,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_kind,
    output logic [3:0]  m_cpu_index,
    output logic [7:0]  m_apic_id,
    output logic [7:0]  m_acpi_id,
    output logic [4:0]  m_cpu_count,
    output logic [31:0] m_ioapic_base,
    output logic        m_stopped_early,
    output logic        m_last
);

    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_valid;
    amep_pkg::parse_evt_t push_evt;
    amep_pkg::parse_evt_t head_evt;

    // Byte parser.
    amep_front #(
        .MAX_CPUS (MAX_CPUS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .s_start_req (s_start_req),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_evt       (push_evt)
    );

    // Request queue.
    amep_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_evt   (push_evt),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_evt   (head_evt)
    );

    // Result sequencer.
    amep_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_evt           (head_evt),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_cpu_index     (m_cpu_index),
        .m_apic_id       (m_apic_id),
        .m_acpi_id       (m_acpi_id),
        .m_cpu_count     (m_cpu_count),
        .m_ioapic_base   (m_ioapic_base),
        .m_stopped_early (m_stopped_early),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire
